### hdl/dsc_pkg.sv
package dsc_pkg;

	// default sizes
	localparam int MAX_SIG_BYTES_DEF = 72;
	localparam int MAX_INT_BYTES_DEF = 33;

	// DER codes
	localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
	localparam logic [7:0] TAG_INTEGER   = 8'h02;
	localparam int         MIN_SIG_BYTES = 8;

	typedef enum logic [7:0] {
		PH_SEQ_TAG = 8'b0000_0001,
		PH_SEQ_LEN = 8'b0000_0010,
		PH_INT_TAG = 8'b0000_0100,
		PH_INT_LEN = 8'b0000_1000,
		PH_FIRST   = 8'b0001_0000,
		PH_SECOND  = 8'b0010_0000,
		PH_REST    = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} dsc_item_t;

endpackage

### hdl/ecdsa_der_signature_strict_check_unit.sv
// Channel  Dir  Fields (tdata / tuser / tlast)
// s_*      in   tdata[7:0] = data_byte, tlast = is_last
// m_*      out  tdata[0] = sig_ok, tdata[7:1] = 0; one item per signature
//
// One byte item per cycle while no last byte stalls. A byte goes into the input register,
// is parsed there combinationally, and the verdict of a last byte is registered
// in the result register.
// Reset (arst_n low) empties both registers and returns the parser to the tag.
// A last byte waits in the input register while the result register is full.
module ecdsa_der_signature_strict_check_unit #(
	parameter int MAX_SIG_BYTES = dsc_pkg::MAX_SIG_BYTES_DEF,
	parameter int MAX_INT_BYTES = dsc_pkg::MAX_INT_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] sig_ok, [7:1] zero
);
	import dsc_pkg::*;

	dsc_item_t item_s1;
	logic      valid_s1;
	logic      out_free;
	logic      adv;
	logic      verdict;
	logic      m_valid_q;
	logic      sig_ok_q;

	assign out_free = !m_valid_q || m_tready;
	assign adv      = valid_s1 && (!item_s1.is_last || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte <= s_tdata;
			item_s1.is_last   <= s_tlast;
		end
	end

	dsc_parser #(
		.MAX_SIG_BYTES(MAX_SIG_BYTES),
		.MAX_INT_BYTES(MAX_INT_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item    (item_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= adv && item_s1.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && item_s1.is_last) begin
			sig_ok_q <= verdict;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, sig_ok_q};

endmodule

### hdl/dsc_parser.sv
module dsc_parser #(
	parameter int MAX_SIG_BYTES = dsc_pkg::MAX_SIG_BYTES_DEF,
	parameter int MAX_INT_BYTES = dsc_pkg::MAX_INT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,      // item in the input stage is consumed this cycle
	input  dsc_pkg::dsc_item_t  item,
	output logic                verdict   // pass/fail of the signature ending with item
);
	import dsc_pkg::*;

	localparam int LEN_W = $clog2(MAX_SIG_BYTES - 1);
	localparam int VAL_W = $clog2(MAX_INT_BYTES + 1);
	localparam logic [7:0] SEQ_LEN_MIN = 8'(MIN_SIG_BYTES - 2);
	localparam logic [7:0] SEQ_LEN_MAX = 8'(MAX_SIG_BYTES - 2);
	localparam logic [7:0] INT_LEN_MAX = 8'(MAX_INT_BYTES);
	localparam logic [VAL_W-1:0] LEFT_FULL = VAL_W'(MAX_INT_BYTES - 1);

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d, len_dec;
	logic [VAL_W-1:0]  left_q, left_d, left_dec;
	logic              idx_q, idx_d;
	logic              zero_q, zero_d;
	logic              fail_q, fail_d;
	logic              value_done;
	logic              full, top, bad_second;
	logic [7:0]        b;

	assign b          = item.data_byte;
	assign len_dec    = len_q - LEN_W'(1);
	assign left_dec   = left_q - VAL_W'(1);
	assign value_done = (left_dec == '0);
	assign full       = (left_q == LEFT_FULL);
	assign top        = b[7];
	// a full-size integer needs the zero pad; otherwise a pad only before a set top bit
	assign bad_second = full ? (!zero_q || !top) : (zero_q && !top);

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		left_d  = left_q;
		idx_d   = idx_q;
		zero_d  = zero_q;
		fail_d  = fail_q;
		if (!fail_q) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					if (b != TAG_SEQUENCE) fail_d = 1'b1;
					else phase_d = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					if (b[7] || b < SEQ_LEN_MIN || b > SEQ_LEN_MAX) begin
						fail_d = 1'b1;
					end else begin
						len_d   = b[LEN_W-1:0];
						phase_d = PH_INT_TAG;
					end
				end
				PH_INT_TAG: begin
					if (len_q < LEN_W'(2) || b != TAG_INTEGER) begin
						fail_d = 1'b1;
					end else begin
						len_d   = len_dec;
						phase_d = PH_INT_LEN;
					end
				end
				PH_INT_LEN: begin
					len_d = len_dec;
					if (b == 8'd0 || b > INT_LEN_MAX || b > 8'(len_dec)) begin
						fail_d = 1'b1;
					end else begin
						left_d  = b[VAL_W-1:0];
						phase_d = PH_FIRST;
					end
				end
				PH_FIRST: begin
					len_d  = len_dec;
					left_d = left_dec;
					if (top) begin
						fail_d = 1'b1;
					end else begin
						zero_d = (b == 8'd0);
						if (!value_done) phase_d = PH_SECOND;
						else if (!idx_q) begin
							idx_d   = 1'b1;
							phase_d = PH_INT_TAG;
						end else phase_d = PH_DONE;
					end
				end
				PH_SECOND: begin
					len_d  = len_dec;
					left_d = left_dec;
					if (bad_second) begin
						fail_d = 1'b1;
					end else if (!value_done) begin
						phase_d = PH_REST;
					end else if (!idx_q) begin
						idx_d   = 1'b1;
						phase_d = PH_INT_TAG;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_REST: begin
					len_d  = len_dec;
					left_d = left_dec;
					if (!value_done) phase_d = PH_REST;
					else if (!idx_q) begin
						idx_d   = 1'b1;
						phase_d = PH_INT_TAG;
					end else phase_d = PH_DONE;
				end
				// trailing bytes after the second integer land here too
				default: fail_d = 1'b1;
			endcase
		end
	end

	assign verdict = !fail_d && (phase_d == PH_DONE) && (len_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			len_q   <= '0;
			left_q  <= '0;
			idx_q   <= 1'b0;
			zero_q  <= 1'b0;
			fail_q  <= 1'b0;
		end else if (adv) begin
			if (item.is_last) begin
				phase_q <= PH_SEQ_TAG;
				len_q   <= '0;
				left_q  <= '0;
				idx_q   <= 1'b0;
				zero_q  <= 1'b0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				len_q   <= len_d;
				left_q  <= left_d;
				idx_q   <= idx_d;
				zero_q  <= zero_d;
				fail_q  <= fail_d;
			end
		end
	end

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parser phase not one-hot");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.is_last |=> phase_q == PH_SEQ_TAG && !fail_q && !idx_q)
		else $error("parser did not restart after last item");

	a_pass_path: assert property (@(posedge clk) disable iff (!arst_n)
		adv && verdict |-> idx_q && !fail_q &&
			(phase_q == PH_FIRST || phase_q == PH_SECOND || phase_q == PH_REST))
		else $error("pass reached outside the second integer's value");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= VAL_W'(MAX_INT_BYTES))
		else $error("value byte count out of range");

endmodule
